// ----- hw/rtl/evad_pkg.sv -----
// evad_pkg: shared types and constants of the energy voice activity detector
// used by evad_ctrl, evad_datapath and energy_voice_activity_detector_unit
// no dependencies
`default_nettype none

package evad_pkg;

    // default sizing
    localparam int VAD_MAX_FRAME   = 8192;
    localparam int VAD_SAMPLE_BITS = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_ADDR_W-1:0] CFG_HP_ENABLE        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HP_ALPHA         = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEECH_THRESHOLD = 2'd2;

    localparam logic [16:0] THR_RESET = 17'd32768;
    localparam logic [16:0] THR_ONE   = 17'd65536;

    // running average weights, 0.95 and 0.05 in q0.16
    localparam logic [15:0] W_OLD = 16'd62259;
    localparam logic [15:0] W_NEW = 16'd3277;

    localparam int FRAC_BITS = 16;
    localparam int ENERGY_W  = 17;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_FILT,
        MUL_THR,
        MUL_OLD,
        MUL_NEW
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     div_init;
        logic     div_step;
        logic     seed_en;
        logic     cmp_en;
        logic     save_en;
        logic     upd_en;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/evad_ctrl.sv -----
// evad_ctrl: sequencer of the voice activity detector, one sample at a time
// drives evad_datapath through t_dp_cmd, depends on evad_pkg
`default_nettype none

module evad_ctrl
    import evad_pkg::*;
#(
    parameter int DIV_STEPS = VAD_SAMPLE_BITS + 1 + $clog2(VAD_MAX_FRAME + 1)
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT,
        S_ACC,
        S_DINIT,
        S_DIV,
        S_SEED,
        S_MTHR,
        S_MOLD,
        S_MNEW,
        S_UPD
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_FILT;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FILT;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state = i_sts.last ? S_DINIT : S_IDLE;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.seed_en = 1'b1;
                n_state = S_MTHR;
            end
            S_MTHR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_THR;
                n_state = S_MOLD;
            end
            S_MOLD: begin
                o_cmd.cmp_en  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_OLD;
                n_state = S_MNEW;
            end
            S_MNEW: begin
                o_cmd.save_en = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NEW;
                n_state = S_UPD;
            end
            S_UPD: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.upd_en = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // divider never runs past its last quotient bit
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step <= STEP_LAST))
        else $error("divider step counter out of range");

    // a frame end with a free output register returns to idle next cycle
    a_upd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !i_sts.out_busy) |=> (r_state == S_IDLE))
        else $error("update did not complete");

    // no new sample is taken while a frame end is being worked out
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> !o_cmd.load_in)
        else $error("sample taken during division");

endmodule

`default_nettype wire

// ----- hw/rtl/evad_datapath.sv -----
// evad_datapath: high-pass filter, energy accumulator, restoring divider,
// shared multiplier, speech decision and output register; depends on evad_pkg
`default_nettype none

module evad_datapath
    import evad_pkg::*;
#(
    parameter int SAMPLE_BITS = VAD_SAMPLE_BITS,
    parameter int MAX_FRAME   = VAD_MAX_FRAME
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_speech,
    output logic [ENERGY_W-1:0]         o_frame_energy
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int Y_W   = SAMPLE_BITS + 2;
    localparam int A_W   = SAMPLE_BITS + 1;
    localparam int SUM_W = A_W + CNT_W;
    localparam int E_W   = SAMPLE_BITS + 1;
    localparam int B_W   = SAMPLE_BITS + 3;
    localparam int P_W   = 18 + B_W;
    localparam int ACC_W = E_W + FRAC_BITS;

    localparam logic signed [Y_W-1:0] FILT_MAX  = Y_W'((1 << (SAMPLE_BITS + 1)) - 1);
    localparam logic signed [P_W-1:0] P_HALF    = P_W'(32768);
    localparam logic [CNT_W-1:0]      CNT_LIMIT = CNT_W'(MAX_FRAME);

    // configuration
    logic        r_hp_en;
    logic [15:0] r_alpha;
    logic [16:0] r_thr;

    // filter and accumulation state
    logic signed [SAMPLE_BITS-1:0] r_x, r_prev;
    logic                          r_last;
    logic signed [Y_W-1:0]         r_y;
    logic                          r_fstart;
    logic [SUM_W-1:0]              r_sum;
    logic [CNT_W-1:0]              r_cnt;

    // multiplier, divider and decision
    logic signed [P_W-1:0] r_prod;
    logic [CNT_W-1:0]      r_rem;
    logic [SUM_W-1:0]      r_quo;
    logic [E_W-1:0]        r_e, r_avg, r_avg_s;
    logic [ACC_W-1:0]      r_acc;
    logic                  r_sp;

    // output register
    logic                r_out_valid;
    logic                r_out_speech;
    logic [ENERGY_W-1:0] r_out_energy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_en <= 1'b0;
            r_alpha <= '0;
            r_thr   <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_HP_ENABLE:        r_hp_en <= i_cfg_data[0];
                CFG_HP_ALPHA:         r_alpha <= i_cfg_data[15:0];
                CFG_SPEECH_THRESHOLD: r_thr   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operands
    logic signed [17:0]    mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [B_W-1:0] filt_t;
    logic [E_W:0]          e_plus_avg;
    logic [16:0]           thr_c;

    assign filt_t     = B_W'(r_y) + B_W'(r_x) - B_W'(r_prev);
    assign e_plus_avg = (E_W + 1)'(r_e) + (E_W + 1)'(r_avg_s);
    assign thr_c      = (r_thr > THR_ONE) ? THR_ONE : r_thr;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_FILT: begin
                mul_a = 18'(r_alpha);
                mul_b = filt_t;
            end
            MUL_THR: begin
                mul_a = 18'(thr_c);
                mul_b = B_W'(e_plus_avg);
            end
            MUL_OLD: begin
                mul_a = 18'(W_OLD);
                mul_b = B_W'(r_avg_s);
            end
            MUL_NEW: begin
                mul_a = 18'(W_NEW);
                mul_b = B_W'(r_e);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // filter output: round, bypass, saturate, magnitude
    logic signed [P_W-1:0] rnd_full;
    logic signed [P_W-1:0] y_raw;
    logic signed [Y_W-1:0] y_sat;
    logic [A_W-1:0]        y_abs;

    assign rnd_full = (r_prod + P_HALF) >>> FRAC_BITS;
    assign y_raw    = (!r_hp_en || r_fstart) ? P_W'(r_x) : rnd_full;

    always_comb begin
        if (y_raw > P_W'(FILT_MAX)) begin
            y_sat = FILT_MAX;
        end else if (y_raw < -P_W'(FILT_MAX)) begin
            y_sat = -FILT_MAX;
        end else begin
            y_sat = Y_W'(y_raw);
        end
    end

    assign y_abs = (y_sat < 0) ? A_W'(-y_sat) : A_W'(y_sat);

    // restoring divider step
    logic [CNT_W-1:0] cnt_div;
    logic [CNT_W:0]   rem_sh;
    logic             rem_ge;

    assign cnt_div = (r_cnt == '0) ? CNT_W'(1) : r_cnt;
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge  = (rem_sh >= (CNT_W + 1)'(cnt_div));

    // speech decision and average update
    logic [E_W-1:0]   q_e;
    logic [P_W-1:0]   e_sh;
    logic [ACC_W:0]   avg_sum;
    logic [E_W-1:0]   avg_new;

    assign q_e     = E_W'(r_quo);
    assign e_sh    = P_W'({r_e, 16'b0});
    assign avg_sum = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(r_prod[ACC_W-1:0])
                   + (ACC_W + 1)'(32768);
    assign avg_new = E_W'(avg_sum >> FRAC_BITS);

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_y         <= '0;
            r_fstart    <= 1'b1;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc_en) begin
                r_y      <= y_sat;
                r_prev   <= r_x;
                r_fstart <= 1'b0;
                if (r_cnt < CNT_LIMIT) begin
                    r_sum <= r_sum + SUM_W'(y_abs);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            // output word: loaded on update, dropped once taken
            if (i_cmd.upd_en) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.upd_en) begin
                r_avg       <= avg_new;
                r_sum       <= '0;
                r_cnt       <= '0;
                r_fstart    <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x    <= i_sample;
            r_last <= i_last;
        end
        if (i_cmd.mul_en) begin
            r_prod <= P_W'(mul_a) * P_W'(mul_b);
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_sum;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? CNT_W'(rem_sh - (CNT_W + 1)'(cnt_div)) : CNT_W'(rem_sh);
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
        if (i_cmd.seed_en) begin
            r_e     <= q_e;
            r_avg_s <= (r_avg == '0) ? q_e : r_avg;
        end
        if (i_cmd.cmp_en) begin
            r_sp <= (r_avg_s == '0) ? (thr_c == '0) : (e_sh >= P_W'(r_prod));
        end
        if (i_cmd.save_en) begin
            r_acc <= ACC_W'(r_prod);
        end
        if (i_cmd.upd_en) begin
            r_out_speech <= r_sp;
            r_out_energy <= ENERGY_W'(r_e);
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_speech       = r_out_speech;
    assign o_frame_energy = r_out_energy;

    // the sample count never passes the frame limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LIMIT)
        else $error("sample count beyond frame limit");

    // a frame end clears the accumulator and presents a word
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_en |=> (r_cnt == '0 && r_sum == '0 && r_fstart && r_out_valid))
        else $error("frame end did not restart accumulation");

    // the mean magnitude fits the filter range
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seed_en |-> ((r_quo >> A_W) == '0))
        else $error("frame energy out of range");

    // a new word is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_en |-> !(r_out_valid && !i_out_ready))
        else $error("output word overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/energy_voice_activity_detector_unit.sv -----
// Energy voice activity detector. Audio samples arrive one word at a time
// on the input channel, with i_last marking the final sample of a frame;
// after each frame one word with the frame's mean absolute (optionally
// high-pass filtered) sample and a speech flag leaves on the output channel.
// An ordinary sample passes through three steps (accept, filter multiply,
// accumulate). A frame-ending sample then adds a divider init and DIV_STEPS
// divide steps, DIV_STEPS = SAMPLE_BITS + 1 + clog2(MAX_FRAME + 1) (31 at
// the defaults): the mean comes from a restoring divider at one quotient
// bit per cycle, then the decision and average update share the single
// multiplier in three steps. If the previous result word has not been
// taken, the frame end waits for it. The user must write configuration
// through a plain write port while the block is idle; it is not enforced.
//
// top level, depends on evad_pkg, evad_ctrl and evad_datapath
`default_nettype none

module energy_voice_activity_detector_unit
    import evad_pkg::*;
#(
    parameter int SAMPLE_BITS = VAD_SAMPLE_BITS,
    parameter int MAX_FRAME   = VAD_MAX_FRAME
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_speech,
    output logic [ENERGY_W-1:0]         o_frame_energy
);

    localparam int DIV_STEPS = SAMPLE_BITS + 1 + $clog2(MAX_FRAME + 1);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    evad_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic and state
    evad_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_FRAME   (MAX_FRAME)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_speech       (o_speech),
        .o_frame_energy (o_frame_energy)
    );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench of energy_voice_activity_detector_unit, with a
// scoreboard class that predicts frame energy and the speech flag per frame
// depends on evad_pkg and the detector rtl

module tb;
    import evad_pkg::*;

    localparam int     SMP_W         = VAD_SAMPLE_BITS;
    localparam longint FILT_MAX      = (longint'(1) << (VAD_SAMPLE_BITS + 1)) - 1;
    localparam int     CYCLE_LIMIT   = 400000;
    // settle margin after the results drain, for any word still in flight
    localparam int     SETTLE_CYCLES = 60;
    localparam int     PHASE_WORDS   = 30;

    typedef struct {
        logic                speech;
        logic [ENERGY_W-1:0] energy;
    } t_frame_result;

    typedef enum {
        AMP_FULL,
        AMP_LOW,
        AMP_SILENT,
        AMP_EDGE
    } t_amp_kind;

    // predictor of the detector plus the queue of frame results still owed
    class vad_frame_checker;
        logic                hp_on;
        logic [15:0]         alpha;
        logic [16:0]         thr;
        logic signed [SMP_W-1:0] prev_x;
        logic signed [SMP_W+1:0] filt_y;
        logic                frame_open;
        logic [30:0]         abs_total;
        logic [13:0]         count;
        logic [ENERGY_W-1:0] avg;
        t_frame_result       pending_frames[$];
        int                  errors;

        function new();
            hp_on      = 1'b0;
            alpha      = '0;
            thr        = THR_RESET;
            prev_x     = '0;
            filt_y     = '0;
            frame_open = 1'b1;
            abs_total  = '0;
            count      = '0;
            avg        = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_HP_ENABLE:        hp_on = data[0];
                CFG_HP_ALPHA:         alpha = data[15:0];
                CFG_SPEECH_THRESHOLD: thr = data[16:0];
                default: ;
            endcase
        endfunction

        // filter one accepted sample word, accumulate, and close the frame on eof
        function void take_sample(logic [SMP_W-1:0] s, logic eof);
            longint        x;
            longint        t;
            longint        y;
            longint        e;
            longint        a;
            longint        lim;
            longint        nxt;
            logic          sp;
            t_frame_result r;

            x = longint'($signed(s));
            if (!hp_on || frame_open) begin
                y = x;
            end else begin
                t = longint'(filt_y) + x - longint'(prev_x);
                y = (longint'(alpha) * t + 32768) >>> 16;
            end
            if (y > FILT_MAX) y = FILT_MAX;
            if (y < -FILT_MAX) y = -FILT_MAX;
            filt_y     = y[SMP_W+1:0];
            prev_x     = s;
            frame_open = 1'b0;

            // samples past the frame size limit are filtered but not summed
            if (count < VAD_MAX_FRAME) begin
                abs_total = 31'(longint'(abs_total) + (y < 0 ? -y : y));
                count     = count + 1'b1;
            end
            if (!eof) return;

            e   = longint'(abs_total) / longint'(count == 0 ? 14'd1 : count);
            lim = (thr > THR_ONE) ? longint'(THR_ONE) : longint'(thr);
            // unseeded average takes the first frame's energy
            a = longint'(avg);
            if (a == 0) a = e;
            if (a == 0) sp = (lim == 0);
            else        sp = ((e << 16) >= lim * (e + a));
            nxt = (longint'(W_OLD) * a + longint'(W_NEW) * e + 32768) >> 16;
            avg = nxt[ENERGY_W-1:0];

            r.speech = sp;
            r.energy = e[ENERGY_W-1:0];
            pending_frames = {pending_frames, r};

            frame_open = 1'b1;
            abs_total  = '0;
            count      = '0;
        endfunction

        function void match_frame(logic speech, logic [ENERGY_W-1:0] energy);
            t_frame_result want;

            if (pending_frames.size() == 0) begin
                $error("result word with no frame pending: speech %0d frame_energy %0d",
                       speech, energy);
                errors++;
                return;
            end
            want = pending_frames.pop_front();
            if (speech !== want.speech) begin
                $error("speech mismatch: expected %0d, actual %0d", want.speech, speech);
                errors++;
            end
            if (energy !== want.energy) begin
                $error("frame_energy mismatch: expected %0d, actual %0d", want.energy, energy);
                errors++;
            end
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic [SMP_W-1:0]      i_sample    = '0;
    logic                  i_last      = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_speech;
    logic [ENERGY_W-1:0]   o_frame_energy;

    logic idle_on     = 1'b1;
    int   ready_wait  = 0;
    int   cycle_count = 0;

    vad_frame_checker vad_sb = new();

    energy_voice_activity_detector_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_speech       (o_speech),
        .o_frame_energy (o_frame_energy)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each accepted word, then hold off ready at random while idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_wait = 0;
        end else if (i_out_ready && o_out_valid) begin
            vad_sb.match_frame(o_speech, o_frame_energy);
            ready_wait = idle_on ? $urandom_range(0, 4) : 0;
            i_out_ready <= (ready_wait == 0);
        end else if (!i_out_ready) begin
            if (ready_wait <= 1) i_out_ready <= 1'b1;
            if (ready_wait > 0) ready_wait--;
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // random sample value of the given amplitude class
    function automatic logic [SMP_W-1:0] make_sample(t_amp_kind kind, int amp);
        int v;

        case (kind)
            AMP_FULL:   v = $urandom;
            AMP_LOW:    v = $urandom_range(0, 2 * amp) - amp;
            AMP_SILENT: v = 0;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v[SMP_W-1:0];
    endfunction

    // send one sample word after a random gap; returns at the accepting edge
    task automatic send_word(input logic [SMP_W-1:0] s, input logic eof);
        int gap;

        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_last     <= eof;
        do @(posedge i_clk); while (!o_in_ready);
        vad_sb.take_sample(s, eof);
    endtask

    // stop sending and wait until every frame result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (vad_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers on consecutive edges, only while idle
    task automatic load_settings(input logic en, input logic [15:0] alpha,
                                 input logic [16:0] thr);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_HP_ENABLE;
        i_cfg_data  <= {16'd0, en};
        vad_sb.write_reg(CFG_HP_ENABLE, {16'd0, en});
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HP_ALPHA;
        i_cfg_data  <= {1'b0, alpha};
        vad_sb.write_reg(CFG_HP_ALPHA, {1'b0, alpha});
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SPEECH_THRESHOLD;
        i_cfg_data  <= thr;
        vad_sb.write_reg(CFG_SPEECH_THRESHOLD, thr);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // one frame of random length and loudness
    task automatic send_random_frame(output int len);
        t_amp_kind kind;
        int        amp;
        int        pick;

        pick = $urandom_range(0, 9);
        len  = (pick < 8) ? $urandom_range(1, 12) : $urandom_range(13, 80);
        pick = $urandom_range(0, 9);
        if (pick < 2)      kind = AMP_FULL;
        else if (pick < 7) kind = AMP_LOW;
        else if (pick < 8) kind = AMP_SILENT;
        else               kind = AMP_EDGE;
        amp = $urandom_range(1, (1 << $urandom_range(1, 15)) - 1);
        for (int i = 0; i < len; i++) send_word(make_sample(kind, amp), i == len - 1);
    endtask

    initial begin
        int          sent;
        int          len;
        logic        en;
        logic [15:0] alpha;
        logic [16:0] thr;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // silent frame at reset settings: average stays unseeded, no speech
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b1);

        // zero average with zero threshold counts as speech
        drain_results();
        load_settings(1'b0, 16'd0, 17'd0);
        send_word(16'h0000, 1'b1);

        // first loud frame seeds the average, threshold of one
        drain_results();
        load_settings(1'b0, 16'd0, THR_ONE);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b1);

        // full-scale swings through the filter, threshold above one
        drain_results();
        load_settings(1'b1, 16'hffff, 17'h1ffff);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b1);

        // zero alpha: only the first sample of the frame survives
        drain_results();
        load_settings(1'b1, 16'd0, THR_RESET);
        send_word(16'h8000, 1'b0);
        send_word(16'h0005, 1'b0);
        send_word(16'h0007, 1'b1);

        // half alpha, mixed signs, then single-sample frames at the extremes
        drain_results();
        load_settings(1'b1, 16'h8000, 17'd16384);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hffff, 1'b0);
        send_word(16'h1234, 1'b1);
        send_word(16'h8000, 1'b1);
        send_word(16'h7fff, 1'b1);

        // random phases, each under its own settings
        for (int ph = 0; ph < 10; ph++) begin
            drain_results();
            en    = (ph % 2 == 0) ? 1'b1 : 1'(($urandom_range(0, 1)));
            alpha = 16'($urandom);
            if (ph == 1) alpha = 16'hffff;
            if (ph == 2) alpha = 16'h0000;
            case (ph)
                1:       thr = 17'd0;
                2:       thr = THR_ONE;
                4:       thr = 17'h1ffff;
                6:       thr = 17'd45000;
                7:       thr = 17'($urandom_range(0, 131071));
                8:       thr = 17'd20000;
                3, 5:    thr = 17'($urandom_range(16384, 49152));
                default: thr = THR_RESET;
            endcase
            load_settings(en, alpha, thr);
            // one phase runs with no idling on either side
            idle_on = (ph != 5);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                send_random_frame(len);
                sent += len;
                // sender holds off until all results are back
                if ($urandom_range(0, 14) == 0) drain_results();
            end
        end

        // trailing frames straight after the last phase
        idle_on = 1'b1;
        send_random_frame(len);
        send_random_frame(len);

        drain_results();
        if (vad_sb.errors == 0 && vad_sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
